// ===== rtl/mipd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_pkg
// Shared types and constants of the modem receive deframer.
// ----------------------------------------------------------------------------
package mipd_pkg;

	// width of the announced payload length and the payload counter
	localparam int LENGTH_BITS = 16;
	// line bytes counted at the head of a line before the counter stops
	localparam int PREFIX_LIMIT = 5;
	localparam int PC_W = $clog2(PREFIX_LIMIT + 1);
	localparam int TMO_W = 16;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	// register reset values
	localparam logic [TMO_W-1:0] PAYLOAD_TMO_RST = TMO_W'(20);
	localparam logic [TMO_W-1:0] LENGTH_TMO_RST = TMO_W'(50);

	// register addresses (word index)
	localparam logic REG_PAYLOAD_TMO = 1'b0;
	localparam logic REG_LENGTH_TMO = 1'b1;

	// input operations
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_LINE_BYTE = 2'd0;
	localparam logic [1:0] KIND_LINE_END = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_PAYLOAD = 2'd3;

	// characters
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_D = 8'h44;

	typedef struct packed {
		logic [TMO_W-1:0] payload_timeout;
		logic [TMO_W-1:0] length_timeout;
	} mipd_cfg_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} mipd_item_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       payload_last;
	} mipd_result_t;

endpackage

// ===== rtl/mipd_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_apb_regs
// APB register file holding the payload and length timeouts.
// ----------------------------------------------------------------------------
module mipd_apb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output mipd_pkg::mipd_cfg_t cfg
);
	import mipd_pkg::*;

	logic [TMO_W-1:0] payload_tmo_q;
	logic [TMO_W-1:0] length_tmo_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_tmo_q <= PAYLOAD_TMO_RST;
			length_tmo_q <= LENGTH_TMO_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_PAYLOAD_TMO: payload_tmo_q <= pwdata[TMO_W-1:0];
				REG_LENGTH_TMO: length_tmo_q <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_PAYLOAD_TMO: prdata = {{(32-TMO_W){1'b0}}, payload_tmo_q};
			REG_LENGTH_TMO: prdata = {{(32-TMO_W){1'b0}}, length_tmo_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.payload_timeout = payload_tmo_q;
	assign cfg.length_timeout = length_tmo_q;

endmodule

// ===== rtl/mipd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_in_reg
// Input register: holds one accepted item until the core processes it.
// ----------------------------------------------------------------------------
module mipd_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mipd_pkg::mipd_item_t in_item,
	input  logic                 take,
	output logic                 valid_s1,
	output mipd_pkg::mipd_item_t item_s1
);
	import mipd_pkg::*;

	// register is free when empty or being consumed this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/mipd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_core
// Deframer state: line, length and payload modes, prefix match, timeout.
// ----------------------------------------------------------------------------
module mipd_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mipd_pkg::mipd_cfg_t    cfg,
	input  logic                   fire,
	input  mipd_pkg::mipd_item_t   item_s1,
	output mipd_pkg::mipd_result_t res
);
	import mipd_pkg::*;

	typedef enum logic [1:0] {
		MODE_LINE    = 2'd0,
		MODE_LENGTH  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	localparam logic [LENGTH_BITS+3:0] TEN = (LENGTH_BITS + 4)'(10);

	mode_t                   mode_q, mode_n, mode_eff;
	logic [PC_W-1:0]         pc_q, pc_n, pc_inc;
	logic [7:0]              pb0_q, pb1_q, pb2_q, pb0_n, pb1_n, pb2_n;
	logic [LENGTH_BITS-1:0]  len_q, len_n;
	logic [LENGTH_BITS-1:0]  cnt_q, cnt_n, cnt_inc;
	logic [TMO_W-1:0]        tmo_q, tmo_n;
	logic [LENGTH_BITS+3:0]  len_mul;
	logic [7:0]              b;
	logic [7:0]              digit;

	assign b = item_s1.data_byte;
	assign digit = b - CH_ZERO;
	assign len_mul = (LENGTH_BITS + 4)'(len_q) * TEN + (LENGTH_BITS + 4)'(digit[3:0]);
	assign cnt_inc = (cnt_q < LEN_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign pc_inc = (pc_q < PC_W'(PREFIX_LIMIT)) ? pc_q + 1'b1 : pc_q;

	// effective mode: a run-out timeout drops back to line mode
	always_comb begin
		mode_eff = mode_q;
		if (mode_q != MODE_LINE && tmo_q == '0) begin
			mode_eff = MODE_LINE;
		end
	end

	// next state and result for the item in the input register
	always_comb begin
		mode_n = mode_q;
		pc_n = pc_q;
		pb0_n = pb0_q;
		pb1_n = pb1_q;
		pb2_n = pb2_q;
		len_n = len_q;
		cnt_n = cnt_q;
		tmo_n = tmo_q;
		res = '0;
		if (item_s1.operation == OP_TICK) begin
			if (tmo_q != '0) begin
				tmo_n = tmo_q - 1'b1;
			end
		end else begin
			unique case (mode_eff)
				MODE_LENGTH: begin
					if (b == CH_COLON) begin
						cnt_n = '0;
						tmo_n = cfg.payload_timeout;
						mode_n = MODE_PAYLOAD;
					end else if (b >= CH_ZERO && b <= CH_NINE) begin
						len_n = (len_mul > (LENGTH_BITS + 4)'(LEN_MAX)) ?
							LEN_MAX : len_mul[LENGTH_BITS-1:0];
					end
				end
				MODE_PAYLOAD: begin
					tmo_n = cfg.payload_timeout;
					cnt_n = cnt_inc;
					res.valid = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.out_byte = b;
					if (cnt_inc >= len_q) begin
						res.payload_last = 1'b1;
						mode_n = MODE_LINE;
					end
				end
				default: begin
					mode_n = MODE_LINE;
					if (b == CH_NL) begin
						pc_n = '0;
						res.valid = 1'b1;
						res.kind = KIND_LINE_END;
					end else if (b != CH_CR) begin
						// keep the first three bytes of the line
						if (pc_q == PC_W'(0)) pb0_n = b;
						if (pc_q == PC_W'(1)) pb1_n = b;
						if (pc_q == PC_W'(2)) pb2_n = b;
						pc_n = pc_inc;
						res.valid = 1'b1;
						if (pc_inc == PC_W'(3) && pb0_n == CH_I && pb1_n == CH_P &&
							pb2_n == CH_D) begin
							mode_n = MODE_LENGTH;
							len_n = '0;
							pc_n = '0;
							tmo_n = cfg.length_timeout;
							res.kind = KIND_CLEAR;
						end else begin
							res.kind = KIND_LINE_BYTE;
							res.out_byte = b;
						end
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINE;
			pc_q <= '0;
			pb0_q <= '0;
			pb1_q <= '0;
			pb2_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			tmo_q <= '0;
		end else if (fire) begin
			mode_q <= mode_n;
			pc_q <= pc_n;
			pb0_q <= pb0_n;
			pb1_q <= pb1_n;
			pb2_q <= pb2_n;
			len_q <= len_n;
			cnt_q <= cnt_n;
			tmo_q <= tmo_n;
		end
	end

endmodule

// ===== rtl/mipd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipd_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module mipd_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  mipd_pkg::mipd_result_t res,
	output logic                   free,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata,
	output logic [1:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);
	import mipd_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;

	// slot can take a new result when empty or drained this cycle
	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			byte_q <= res.out_byte;
			kind_q <= res.kind;
			last_q <= res.payload_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = byte_q;
	assign m_axis_tuser = kind_q;
	assign m_axis_tlast = last_q;

endmodule

// ===== rtl/modem_ipd_receive_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_ipd_receive_deframer
// Splits a modem receive stream into reply lines and IPD payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries received serial bytes (tuser 0) and millisecond ticks
//   (tuser 1). m_axis carries results: tuser is the kind (line byte, line
//   end, clear line buffer, payload byte), tdata the byte, tlast marks the
//   byte that completes an announced payload. Ticks, carriage returns and
//   bytes of the length field give no result.
//   The APB port holds the payload timeout (0x0) and length timeout (0x4).
// Timing:
//   an item is held in the input register and, once the output register is
//   free, its result is registered in the output register, which drives
//   m_axis_tvalid. One item per cycle is sustained while m_axis_tready
//   stays high; the state update for each item is a single pass through
//   the core logic.
// Reset:
//   line mode, counters and timeout cleared, timeouts back to 20 and 50.
// Stall:
//   with m_axis_tready low the output register holds its result, the input
//   register fills and then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module modem_ipd_receive_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] operation
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast
);
	import mipd_pkg::*;

	mipd_cfg_t    cfg;
	mipd_item_t   in_item;
	mipd_item_t   item_s1;
	mipd_result_t res;
	logic         valid_s1;
	logic         out_free;
	logic         fire;

	assign in_item.operation = s_axis_tuser;
	assign in_item.data_byte = s_axis_tdata;

	// item in the input register is processed when the result slot is free
	assign fire = valid_s1 && out_free;

	mipd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mipd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mipd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.item_s1 (item_s1),
		.res     (res)
	);

	mipd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// only payload bytes can close a payload
	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PAYLOAD)
		else $error("tlast on a non-payload result");

	// line end and clear results carry no byte
	a_ctrl_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_LINE_END || m_axis_tuser == KIND_CLEAR)
		|-> m_axis_tdata == 8'h00)
		else $error("control result with nonzero byte");

	// an unprocessed item stays in the input register untouched
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("input register lost or changed a pending item");

	// ticks never produce a result
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.operation == OP_TICK |-> !res.valid)
		else $error("tick produced a result");
`endif

endmodule

// ===== verif/tb_modem_ipd_receive_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modem_ipd_receive_deframer
// Self-checking bench for the modem receive deframer. A short table of
// directed bytes and ticks with typed-in results runs first. Random reply
// lines, IPD frames (well-formed, truncated, timed out, saturating), broken
// prefixes and noise follow under several timeout settings, checked
// against an in-bench model of the line/length/payload state machine.
// Both stream sides idle at random; timeouts are rewritten over APB
// between phases.
// ----------------------------------------------------------------------------
module tb_modem_ipd_receive_deframer;
	import mipd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int ITEMS_PER_PHASE = 275;
	localparam int NUM_PHASES = 7;
	localparam int DIR_ROWS = 25;
	localparam int SIDE_SRC = 0;
	localparam int SIDE_SINK = 1;

	typedef enum logic [1:0] {
		DF_LINE    = 2'd0,
		DF_LENGTH  = 2'd1,
		DF_PAYLOAD = 2'd2
	} df_mode_t;

	typedef struct {
		logic       op;
		logic [7:0] data;
		logic       has_res;
		logic [1:0] kind;
		logic [7:0] obyte;
		logic       last;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // [7:0] data_byte
	logic        s_axis_tuser;  // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [7:0] out_byte
	logic [1:0]  m_axis_tuser;  // [1:0] kind
	logic        m_axis_tlast;

	// deframer model state and its copy of the registers
	df_mode_t               cur_mode;
	logic [PC_W-1:0]        prefix_cnt;
	logic [7:0]             prefix_buf [3];
	logic [LENGTH_BITS-1:0] pay_len;
	logic [LENGTH_BITS-1:0] pay_cnt;
	logic [TMO_W-1:0]       tmo_left;
	mipd_cfg_t              cfg;

	mipd_result_t deframed_q [$];
	int           mismatch_count;
	int           items_sent;
	int           burst_left [2];
	dir_row_t     dir_rows [DIR_ROWS];

	modem_ipd_receive_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// one input item through the deframer model
	function automatic mipd_result_t deframe_step(input mipd_item_t it);
		mipd_result_t r;
		logic [7:0]   b;
		logic [19:0]  acc;
		r = '0;
		b = it.data_byte;
		if (it.operation == OP_TICK) begin
			if (tmo_left != '0)
				tmo_left--;
			return r;
		end
		// timed out in length or payload mode: handle the byte as text
		if (cur_mode != DF_LINE && tmo_left == '0)
			cur_mode = DF_LINE;
		case (cur_mode)
			DF_LENGTH: begin
				if (b == CH_COLON) begin
					pay_cnt = '0;
					tmo_left = cfg.payload_timeout;
					cur_mode = DF_PAYLOAD;
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					acc = 20'(pay_len) * 20'd10 + 20'(b - CH_ZERO);
					pay_len = (acc > 20'(LEN_MAX)) ? LEN_MAX : acc[LENGTH_BITS-1:0];
				end
			end
			DF_PAYLOAD: begin
				tmo_left = cfg.payload_timeout;
				if (pay_cnt != LEN_MAX)
					pay_cnt++;
				r.valid = 1'b1;
				r.kind = KIND_PAYLOAD;
				r.out_byte = b;
				if (pay_cnt >= pay_len) begin
					r.payload_last = 1'b1;
					cur_mode = DF_LINE;
				end
			end
			default: begin
				cur_mode = DF_LINE;
				if (b == CH_NL) begin
					prefix_cnt = '0;
					r.valid = 1'b1;
					r.kind = KIND_LINE_END;
				end else if (b != CH_CR) begin
					if (prefix_cnt < PC_W'(PREFIX_LIMIT)) begin
						if (prefix_cnt < 3)
							prefix_buf[prefix_cnt[1:0]] = b;
						prefix_cnt++;
					end
					r.valid = 1'b1;
					if (prefix_cnt == 3 && prefix_buf[0] == CH_I && prefix_buf[1] == CH_P &&
					    prefix_buf[2] == CH_D) begin
						cur_mode = DF_LENGTH;
						pay_len = '0;
						prefix_cnt = '0;
						tmo_left = cfg.length_timeout;
						r.kind = KIND_CLEAR;
					end else begin
						r.kind = KIND_LINE_BYTE;
						r.out_byte = b;
					end
				end
			end
		endcase
		return r;
	endfunction

	// random wait per transaction, with stretches of back-to-back traffic
	function automatic int draw_wait(input int side);
		if (burst_left[side] > 0) begin
			burst_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left[side] = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	// drive one item, predict at acceptance
	task automatic send_item(input mipd_item_t it, input bit typed, input mipd_result_t typed_res);
		int           gap;
		mipd_result_t r;
		gap = draw_wait(SIDE_SRC);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.operation;
		s_axis_tdata <= it.data_byte;
		do @(posedge clk); while (!s_axis_tready);
		r = deframe_step(it);
		if (typed)
			r = typed_res;
		if (r.valid)
			deframed_q.push_back(r);
		items_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		mipd_item_t it;
		it.operation = OP_BYTE;
		it.data_byte = b;
		send_item(it, 1'b0, '0);
	endtask

	task automatic send_tick();
		mipd_item_t it;
		it.operation = OP_TICK;
		it.data_byte = 8'($urandom);
		send_item(it, 1'b0, '0);
	endtask

	// stop sending until every predicted result has come out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb read of a timeout register, compared with the expected value
	task automatic check_reg(input logic reg_idx, input logic [TMO_W-1:0] want);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== 32'(want)) begin
			$error("%s: expected %0d, got %0d",
			       (reg_idx == REG_PAYLOAD_TMO) ? "payload_timeout" : "length_timeout",
			       want, got);
			mismatch_count++;
		end
	endtask

	// apb write, junk in the unused upper bits, then read back
	task automatic cfg_write(input logic reg_idx, input logic [TMO_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_PAYLOAD_TMO)
			cfg.payload_timeout = val;
		else
			cfg.length_timeout = val;
		check_reg(reg_idx, val);
	endtask

	// IPD<len>:<payload>, sometimes saturated, truncated or timed out
	task automatic gen_frame();
		int         len;
		int         n;
		int         choice;
		bit         short_tmo;
		bit         trunc;
		string      digits;
		logic [7:0] junk;
		short_tmo = (cfg.payload_timeout <= 100) && (cfg.length_timeout <= 100);
		choice = $urandom_range(0, 99);
		if (prefix_cnt != '0 || $urandom_range(0, 3) == 0)
			put_byte(CH_NL);
		put_byte(CH_I);
		put_byte(CH_P);
		put_byte(CH_D);
		if (short_tmo && choice < 6) begin
			// long digit string, length may saturate
			repeat ($urandom_range(5, 7)) put_byte(CH_ZERO + 8'($urandom_range(1, 9)));
		end else begin
			len = (choice < 60) ? $urandom_range(0, 8) : $urandom_range(9, 64);
			if ($urandom_range(0, 4) == 0)
				put_byte(CH_ZERO);
			digits = $sformatf("%0d", len);
			for (int i = 0; i < digits.len(); i++) begin
				put_byte(digits[i]);
				if ($urandom_range(0, 9) == 0)
					send_tick();
				if ($urandom_range(0, 9) == 0) begin
					// non-digit bytes in the length field are skipped
					junk = 8'($urandom);
					if ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_COLON)
						junk = 8'h2c;
					put_byte(junk);
				end
			end
		end
		if (short_tmo && $urandom_range(0, 9) == 0) begin
			// let the length field run out of time
			while (tmo_left != '0) send_tick();
			return;
		end
		put_byte(CH_COLON);
		n = (pay_len == '0) ? 1 : int'(pay_len);
		trunc = short_tmo && (pay_len > 64 || $urandom_range(0, 9) == 0);
		if (trunc)
			n = $urandom_range(1, 8);
		if (n > 64)
			n = 64;
		repeat (n) begin
			put_byte(8'($urandom));
			if ($urandom_range(0, 7) == 0)
				send_tick();
		end
		if (trunc)
			while (tmo_left != '0 && cur_mode != DF_LINE) send_tick();
	endtask

	// ordinary reply line
	task automatic gen_text_line();
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 3) == 0)
				put_byte(8'($urandom));
			else
				put_byte(8'($urandom_range(8'h20, 8'h7e)));
		end
		if ($urandom_range(0, 1) == 1)
			put_byte(CH_CR);
		put_byte(CH_NL);
	endtask

	// broken prefixes, stray bytes and ticks
	task automatic gen_noise();
		if ($urandom_range(0, 2) == 0) begin
			put_byte(CH_I);
			put_byte(CH_P);
			put_byte(8'($urandom));
		end
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 2) == 0)
				send_tick();
			else
				put_byte(8'($urandom));
		end
	endtask

	// bring the block back to line mode before the next sequence
	task automatic recover_line_mode();
		while (cur_mode != DF_LINE) begin
			if (tmo_left == '0)
				put_byte(CH_NL);
			else if (tmo_left <= 64)
				send_tick();
			else if (cur_mode == DF_LENGTH && pay_len <= 64)
				put_byte(CH_COLON);
			else if (cur_mode == DF_PAYLOAD && (pay_len - pay_cnt) <= 64)
				put_byte(8'($urandom));
			else
				send_tick();
		end
	endtask

	// result side: random stalls, compare each transaction
	initial begin
		int           stall;
		mipd_result_t e;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(SIDE_SINK);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			if (deframed_q.size() == 0) begin
				$error("unexpected result: kind %0d, out_byte %02h, payload_last %0b",
				       m_axis_tuser, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				e = deframed_q.pop_front();
				if (m_axis_tuser !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata !== e.out_byte) begin
					$error("out_byte: expected %02h, got %02h", e.out_byte, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== e.payload_last) begin
					$error("payload_last: expected %0b, got %0b", e.payload_last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
			    !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		mipd_item_t   it;
		mipd_result_t res;
		int           phase_end;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_BYTE;
		mismatch_count = 0;
		items_sent = 0;
		burst_left[SIDE_SRC] = 0;
		burst_left[SIDE_SINK] = 0;
		cur_mode = DF_LINE;
		prefix_cnt = '0;
		prefix_buf[0] = '0;
		prefix_buf[1] = '0;
		prefix_buf[2] = '0;
		pay_len = '0;
		pay_cnt = '0;
		tmo_left = '0;
		cfg.payload_timeout = PAYLOAD_TMO_RST;
		cfg.length_timeout = LENGTH_TMO_RST;

		// directed rows, reset timeouts
		dir_rows = '{
			'{OP_BYTE, 8'h41,    1'b1, KIND_LINE_BYTE, 8'h41,    1'b0}, // A
			'{OP_BYTE, 8'h00,    1'b1, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, 8'hff,    1'b1, KIND_LINE_BYTE, 8'hff,    1'b0},
			// IPD past the third byte of a line is plain text
			'{OP_BYTE, CH_I,     1'b1, KIND_LINE_BYTE, CH_I,     1'b0},
			'{OP_BYTE, CH_P,     1'b1, KIND_LINE_BYTE, CH_P,     1'b0},
			'{OP_BYTE, CH_D,     1'b1, KIND_LINE_BYTE, CH_D,     1'b0},
			'{OP_BYTE, CH_CR,    1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, CH_NL,    1'b1, KIND_LINE_END,  8'h00,    1'b0},
			'{OP_BYTE, CH_I,     1'b1, KIND_LINE_BYTE, CH_I,     1'b0},
			'{OP_BYTE, CH_P,     1'b1, KIND_LINE_BYTE, CH_P,     1'b0},
			'{OP_BYTE, CH_D,     1'b1, KIND_CLEAR,     8'h00,    1'b0},
			'{OP_BYTE, CH_ZERO,  1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, 8'h32,    1'b0, KIND_LINE_BYTE, 8'h00,    1'b0}, // 2
			'{OP_BYTE, 8'h2c,    1'b0, KIND_LINE_BYTE, 8'h00,    1'b0}, // skipped comma
			'{OP_BYTE, CH_COLON, 1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_TICK, 8'hff,    1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, 8'h00,    1'b1, KIND_PAYLOAD,   8'h00,    1'b0},
			'{OP_BYTE, 8'hff,    1'b1, KIND_PAYLOAD,   8'hff,    1'b1},
			// zero length still carries one byte
			'{OP_BYTE, CH_I,     1'b1, KIND_LINE_BYTE, CH_I,     1'b0},
			'{OP_BYTE, CH_P,     1'b1, KIND_LINE_BYTE, CH_P,     1'b0},
			'{OP_BYTE, CH_D,     1'b1, KIND_CLEAR,     8'h00,    1'b0},
			'{OP_BYTE, CH_COLON, 1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, 8'h5a,    1'b1, KIND_PAYLOAD,   8'h5a,    1'b1},
			'{OP_TICK, 8'h00,    1'b0, KIND_LINE_BYTE, 8'h00,    1'b0},
			'{OP_BYTE, 8'h78,    1'b1, KIND_LINE_BYTE, 8'h78,    1'b0}  // x
		};

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		check_reg(REG_PAYLOAD_TMO, PAYLOAD_TMO_RST);
		check_reg(REG_LENGTH_TMO, LENGTH_TMO_RST);

		foreach (dir_rows[i]) begin
			it.operation = dir_rows[i].op;
			it.data_byte = dir_rows[i].data;
			res.valid = dir_rows[i].has_res;
			res.kind = dir_rows[i].kind;
			res.out_byte = dir_rows[i].obyte;
			res.payload_last = dir_rows[i].last;
			send_item(it, 1'b1, res);
		end
		drain_results();

		// random phases under different timeout settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: ;
				1: begin
					cfg_write(REG_PAYLOAD_TMO, 16'd1);
					cfg_write(REG_LENGTH_TMO, 16'd1);
				end
				2: begin
					cfg_write(REG_PAYLOAD_TMO, 16'd0);
					cfg_write(REG_LENGTH_TMO, 16'd0);
				end
				3: begin
					cfg_write(REG_LENGTH_TMO, 16'hffff);
					cfg_write(REG_PAYLOAD_TMO, 16'hffff);
				end
				4: begin
					cfg_write(REG_PAYLOAD_TMO, 16'd2);
					cfg_write(REG_LENGTH_TMO, 16'd5);
				end
				5: begin
					cfg_write(REG_PAYLOAD_TMO, 16'($urandom_range(0, 30)));
					cfg_write(REG_LENGTH_TMO, 16'($urandom_range(0, 30)));
				end
				default: begin
					cfg_write(REG_PAYLOAD_TMO, 16'($urandom));
					cfg_write(REG_LENGTH_TMO, 16'($urandom));
				end
			endcase
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gen_frame();
					11, 12, 13, 14, 15: gen_text_line();
					default: gen_noise();
				endcase
				recover_line_mode();
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
